// File: design/crl_pkg.sv
// crl_pkg: shared types, constants and opcodes of the clip region rectangle list
// depends on nothing
package crl_pkg;

  localparam int MAX_RECTS  = 32;
  localparam int COORD_BITS = 16;
  localparam int CNT_BITS   = 6;
  localparam int IDX_BITS   = $clog2(MAX_RECTS);
  localparam int RECT_BITS  = 4 * COORD_BITS;

  localparam logic [3:0] OP_CLEAR   = 4'd0;
  localparam logic [3:0] OP_SET     = 4'd1;
  localparam logic [3:0] OP_INCLUDE = 4'd2;
  localparam logic [3:0] OP_EXCLUDE = 4'd3;
  localparam logic [3:0] OP_OFFSET  = 4'd4;
  localparam logic [3:0] OP_CONTAIN = 4'd5;
  localparam logic [3:0] OP_ISECT   = 4'd6;
  localparam logic [3:0] OP_FRAME   = 4'd7;
  localparam logic [3:0] OP_READ    = 4'd8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    logic [3:0] opcode;
    coord_t     a_left;
    coord_t     a_top;
    coord_t     a_right;
    coord_t     a_bottom;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [CNT_BITS-1:0] rect_count;
    coord_t              out_left;
    coord_t              out_top;
    coord_t              out_right;
    coord_t              out_bottom;
    logic                out_valid;
    logic                overflow;
  } out_item_t;

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: design/crl_ram.sv
// crl_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module crl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/clip_region_rect_list.sv
// clip_region_rect_list: top level of the clip region rectangle list
// depends on crl_pkg and crl_ram
//
// usage
//   in channel (in_valid, in_stall, in_item) carries one opcode item with
//   its operands; out channel (out_valid, out_stall, out_item) returns
//   exactly one result item per input item, in order
//   clear, set, include and unused opcodes go from idle straight to finish
//   read fetches the addressed entry in an evaluate step before it finishes
//   offset, contains, intersects and frame walk the list through the
//   store ram, each entry read and then evaluated, one entry at a time;
//   contains and intersects stop at a hit
//   exclude walks the list the same way, steps through the four band slots
//   of each partly covered entry to emit its bands into a side ram, then
//   copies the bands behind the survivors, one read and one write per band
//   the single read port of the store ram paces these walks
//   in_stall is low only while the block is idle; one item at a time
//   the result sits in an output register; a stalled receiver holds it
//   there, and the next item may already be accepted and worked on
//   reset (rst_n low, synchronous) empties the list and drops any result
module clip_region_rect_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output crl_pkg::out_item_t out_item
);

  localparam int IW = crl_pkg::IDX_BITS;
  localparam int CW = crl_pkg::CNT_BITS;
  localparam int CB = crl_pkg::COORD_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_PIECE = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;
  localparam logic [2:0] S_CWR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [3:0]          op_r, op_nxt;
  crl_pkg::rect_t      q_r, q_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;     // stored entries
  logic [IW-1:0]       idx_r, idx_nxt;     // walk position
  logic [CW-1:0]       w_r, w_nxt;         // survivors kept so far
  logic [CW-1:0]       pc_r, pc_nxt;       // bands in the side ram
  logic [CW-1:0]       cp_r, cp_nxt;       // copy position
  logic [1:0]          ps_r, ps_nxt;       // band slot
  logic [3:0]          pf_r, pf_nxt;       // band slot flags
  crl_pkg::rect_t      pcs_r [4];
  crl_pkg::rect_t      pcs_nxt [4];
  logic                hit_r, hit_nxt;
  logic                ovf_r, ovf_nxt;
  logic                rv_r, rv_nxt;
  crl_pkg::rect_t      res_r, res_nxt;
  logic                ovld_r, ovld_nxt;
  crl_pkg::out_item_t  oitem_r, oitem_nxt;

  // store ram and band ram ports
  logic                m_we, p_we;
  logic [IW-1:0]       m_waddr, m_raddr, p_waddr, p_raddr;
  crl_pkg::rect_t      m_wdata, p_wdata;
  logic [crl_pkg::RECT_BITS-1:0] m_rdata, p_rdata;

  crl_ram #(.WIDTH(crl_pkg::RECT_BITS), .DEPTH(crl_pkg::MAX_RECTS)) u_store (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  crl_ram #(.WIDTH(crl_pkg::RECT_BITS), .DEPTH(crl_pkg::MAX_RECTS)) u_bands (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;
  assign out_item  = oitem_r;

  always_comb begin
    crl_pkg::rect_t s;
    crl_pkg::coord_t mt, mb;
    logic ovl, cov, adv, last, idx_ok;
    logic [CW:0] room;
    logic [CW-1:0] cp_inc;

    state_nxt = state_r;
    op_nxt    = op_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    w_nxt     = w_r;
    pc_nxt    = pc_r;
    cp_nxt    = cp_r;
    ps_nxt    = ps_r;
    pf_nxt    = pf_r;
    pcs_nxt   = pcs_r;
    hit_nxt   = hit_r;
    ovf_nxt   = ovf_r;
    rv_nxt    = rv_r;
    res_nxt   = res_r;
    ovld_nxt  = ovld_r && out_stall;
    oitem_nxt = oitem_r;

    m_we    = 1'b0;
    m_waddr = idx_r;
    m_wdata = q_r;
    m_raddr = idx_r;
    p_we    = 1'b0;
    p_waddr = pc_r[IW-1:0];
    p_wdata = pcs_r[ps_r];
    p_raddr = cp_r[IW-1:0];

    s    = crl_pkg::rect_t'(m_rdata);
    mt   = crl_pkg::cmax(s.t, q_r.t);
    mb   = crl_pkg::cmin(s.b, q_r.b);
    ovl  = (crl_pkg::cmax(s.l, q_r.l) <= crl_pkg::cmin(s.r, q_r.r)) && (mt <= mb);
    cov  = (q_r.l <= s.l) && (q_r.r >= s.r) && (q_r.t <= s.t) && (q_r.b >= s.b);
    adv  = 1'b0;
    last = (({1'b0, idx_r} + (IW+1)'(1)) == (IW+1)'(cnt_r));
    // entries in use at the time a band is appended: survivors, unvisited, bands
    room = {1'b0, w_r} + {1'b0, cnt_r} - (CW+1)'(idx_r) - (CW+1)'(1) + {1'b0, pc_r};
    cp_inc = cp_r + CW'(1);
    idx_ok = !in_item.a_left[CB-1] &&
             ($unsigned(in_item.a_left) < CB'(cnt_r));

    case (state_r)
      S_IDLE: begin
        m_raddr = (in_item.opcode == crl_pkg::OP_READ) ? in_item.a_left[IW-1:0] : '0;
        if (in_valid) begin
          op_nxt   = in_item.opcode;
          q_nxt    = '{in_item.a_left, in_item.a_top, in_item.a_right, in_item.a_bottom};
          hit_nxt  = 1'b0;
          ovf_nxt  = 1'b0;
          rv_nxt   = 1'b0;
          res_nxt  = '0;
          idx_nxt  = '0;
          w_nxt    = '0;
          pc_nxt   = '0;
          state_nxt = S_FIN;
          case (in_item.opcode)
            crl_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            crl_pkg::OP_SET: begin
              m_we    = 1'b1;
              m_waddr = '0;
              m_wdata = q_nxt;
              cnt_nxt = CW'(1);
            end
            crl_pkg::OP_INCLUDE: begin
              if (cnt_r != CW'(crl_pkg::MAX_RECTS)) begin
                m_we    = 1'b1;
                m_waddr = cnt_r[IW-1:0];
                m_wdata = q_nxt;
                cnt_nxt = cnt_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            crl_pkg::OP_EXCLUDE, crl_pkg::OP_OFFSET, crl_pkg::OP_CONTAIN,
            crl_pkg::OP_ISECT, crl_pkg::OP_FRAME: begin
              if (cnt_r != '0) begin
                state_nxt = S_EVAL;
              end
            end
            crl_pkg::OP_READ: begin
              if (idx_ok) begin
                rv_nxt    = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ISSUE: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        case (op_r)
          crl_pkg::OP_READ: begin
            res_nxt   = s;
            state_nxt = S_FIN;
          end
          crl_pkg::OP_OFFSET: begin
            m_we    = 1'b1;
            m_wdata = '{s.l + q_r.l, s.t + q_r.t, s.r + q_r.l, s.b + q_r.t};
            adv     = 1'b1;
          end
          crl_pkg::OP_CONTAIN: begin
            if (q_r.l >= s.l && q_r.l <= s.r && q_r.t >= s.t && q_r.t <= s.b) begin
              hit_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              adv = 1'b1;
            end
          end
          crl_pkg::OP_ISECT: begin
            if (ovl) begin
              hit_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              adv = 1'b1;
            end
          end
          crl_pkg::OP_FRAME: begin
            if (idx_r == '0) begin
              res_nxt = s;
            end else begin
              res_nxt = '{crl_pkg::cmin(res_r.l, s.l), crl_pkg::cmin(res_r.t, s.t),
                          crl_pkg::cmax(res_r.r, s.r), crl_pkg::cmax(res_r.b, s.b)};
            end
            adv = 1'b1;
          end
          crl_pkg::OP_EXCLUDE: begin
            if (!ovl) begin
              // survivor moves down to the compacted position
              m_we    = 1'b1;
              m_waddr = w_r[IW-1:0];
              m_wdata = s;
              w_nxt   = w_r + CW'(1);
              adv     = 1'b1;
            end else if (cov) begin
              adv = 1'b1;
            end else begin
              // above, below, left, right bands clipped to the entry
              pf_nxt     = {q_r.r < s.r, q_r.l > s.l, q_r.b < s.b, q_r.t > s.t};
              pcs_nxt[0] = '{s.l, s.t, s.r, q_r.t - CB'(1)};
              pcs_nxt[1] = '{s.l, q_r.b + CB'(1), s.r, s.b};
              pcs_nxt[2] = '{s.l, mt, q_r.l - CB'(1), mb};
              pcs_nxt[3] = '{q_r.r + CB'(1), mt, s.r, mb};
              ps_nxt     = '0;
              state_nxt  = S_PIECE;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_PIECE: begin
        if (pf_r[ps_r]) begin
          if (room < (CW+1)'(crl_pkg::MAX_RECTS)) begin
            p_we   = 1'b1;
            pc_nxt = pc_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (ps_r == 2'd3) begin
          adv = 1'b1;
        end else begin
          ps_nxt = ps_r + 2'd1;
        end
      end

      S_CRD: begin
        state_nxt = S_CWR;
      end

      S_CWR: begin
        m_we    = 1'b1;
        m_waddr = IW'(w_r + cp_r);
        m_wdata = crl_pkg::rect_t'(p_rdata);
        cp_nxt  = cp_inc;
        if (cp_inc == pc_r) begin
          cnt_nxt   = w_r + pc_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CRD;
        end
      end

      S_FIN: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt  = 1'b1;
          oitem_nxt = '{hit_r, cnt_r, res_r.l, res_r.t, res_r.r, res_r.b, rv_r, ovf_r};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next entry or close the walk
    if (adv) begin
      if (last) begin
        if (op_r == crl_pkg::OP_EXCLUDE) begin
          if (pc_nxt != '0) begin
            cp_nxt    = '0;
            state_nxt = S_CRD;
          end else begin
            cnt_nxt   = w_nxt;
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end else begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_ISSUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    q_r     <= q_nxt;
    idx_r   <= idx_nxt;
    w_r     <= w_nxt;
    pc_r    <= pc_nxt;
    cp_r    <= cp_nxt;
    ps_r    <= ps_nxt;
    pf_r    <= pf_nxt;
    pcs_r   <= pcs_nxt;
    hit_r   <= hit_nxt;
    ovf_r   <= ovf_nxt;
    rv_r    <= rv_nxt;
    res_r   <= res_nxt;
    oitem_r <= oitem_nxt;
  end

endmodule

// File: design/crl_checker.sv
// crl_checker: port-level assertions for clip_region_rect_list, with its bind
// depends on crl_pkg
module crl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input crl_pkg::out_item_t out_item
);

  // count never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.rect_count <= 6'(crl_pkg::MAX_RECTS)))
    else $error("rect_count above capacity");

  // a valid read result carries no hit and no overflow
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_valid) |-> (!out_item.hit && !out_item.overflow))
    else $error("read result with hit or overflow");

  // reset drops any pending result
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an item");

endmodule

bind clip_region_rect_list crl_checker u_crl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
